@@ rtl/spls_pkg.sv @@
// Package for the square path leg sequencer: payload types, constants, angle table.
package spls_pkg;

   localparam int AngleIterationsDefault = 14;
   localparam int AngleIterationsMax     = 20;

   localparam logic signed [15:0] Q13Pi     = 16'sd25736;
   localparam logic signed [16:0] Q13HalfPi = 17'sd12868;
   localparam logic signed [17:0] Q13TwoPi  = 18'sd51472;
   localparam logic [7:0]         FwdSpeed  = 8'd200;
   localparam logic signed [9:0]  TurnLeft  = 10'sd300;
   localparam logic signed [9:0]  TurnRight = -10'sd300;
   localparam logic [1:0]         SidesLast = 2'd3;

   localparam logic [1:0] CsrSideLength   = 2'd0;
   localparam logic [1:0] CsrLapTarget    = 2'd1;
   localparam logic [1:0] CsrTurnClockwise = 2'd2;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [15:0] quat_w;
      logic signed [15:0] quat_x;
      logic signed [15:0] quat_y;
      logic signed [15:0] quat_z;
   } req_type;

   typedef struct packed {
      logic [7:0]        linear_speed;
      logic signed [9:0] angular_speed;
      logic signed [15:0] heading;
      logic [1:0]        side_index;
      logic [7:0]        laps_done;
      logic              turning;
      logic              finished;
   } rsp_type;

   // atan(2^-i), radians Q3.13
   function automatic logic [12:0] atan_entry(input logic [4:0] i);
      case (i)
         5'd0:  atan_entry = 13'd6434;
         5'd1:  atan_entry = 13'd3798;
         5'd2:  atan_entry = 13'd2007;
         5'd3:  atan_entry = 13'd1019;
         5'd4:  atan_entry = 13'd511;
         5'd5:  atan_entry = 13'd256;
         5'd6:  atan_entry = 13'd128;
         5'd7:  atan_entry = 13'd64;
         5'd8:  atan_entry = 13'd32;
         5'd9:  atan_entry = 13'd16;
         5'd10: atan_entry = 13'd8;
         5'd11: atan_entry = 13'd4;
         5'd12: atan_entry = 13'd2;
         5'd13: atan_entry = 13'd1;
         default: atan_entry = 13'd0;
      endcase
   endfunction

endpackage

@@ rtl/square_path_leg_sequencer.sv @@
// Top level: square path leg sequencer.
// Usage:
//  - req_* takes one odometry item (position, quaternion) when req_valid is
//    high and req_stall is low. req_stall is high while an item is in work.
//  - rsp_* gives one result item per input item: speed commands, heading,
//    side and lap counts, turning and finished flags.
//  - csr_* writes leg length (0), lap_target (1), turn_clockwise (2);
//    csr_ready is always high, other indexes are ignored.
// Each item passes through the iterative CORDIC unit and the one shared
// 33x33 multiplier, which forms the quaternion products, the squared side
// length and the squared distances in turn. One item is in work at a time;
// the next item is taken only after the previous result has been loaded
// into the output register.
// Reset: synchronous, active high; registers return to their reset values,
// the sequencer goes idle, no result is pending.
// A stalled result holds in the output register while the next item is
// worked on; that item waits in its last step until the register frees.
module square_path_leg_sequencer import spls_pkg::*; #(
   parameter int ANGLE_ITERATIONS = AngleIterationsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_wdata
);

   typedef enum logic [3:0] {
      S_IDLE, S_M0, S_M1, S_M2, S_M3, S_ATAN, S_WAIT, S_D0, S_D1, S_DECIDE, S_OUT
   } state_type;

   state_type state_ff;
   req_type item_ff;
   rsp_type rsp_ff;
   logic rsp_valid_ff;
   logic [23:0] leg_len_ff;
   logic [7:0] lap_target_ff;
   logic turn_cw_ff;
   logic fwd_ff, done_flag_ff;
   logic [1:0] side_ff;
   logic [7:0] lap_ff;
   logic signed [31:0] start_x_ff, start_y_ff;
   logic signed [15:0] start_h_ff;
   logic signed [33:0] sin_ff, cos_ff;
   logic [64:0] d2_ff;
   logic [63:0] side2_ff;
   logic signed [15:0] heading_ff;
   logic cordic_start;
   logic cordic_done;
   logic signed [15:0] cordic_angle;

   // shared multiplier, operands chosen by state, product registered
   logic [32:0] mul_a, mul_b;
   logic        mul_signed;
   logic [65:0] prod_ff;
   logic signed [65:0] prod_s;
   logic signed [32:0] dx, dy;
   logic [32:0] ax, ay;

   assign dx = 33'(item_ff.pos_x) - 33'(start_x_ff);
   assign dy = 33'(item_ff.pos_y) - 33'(start_y_ff);
   assign ax = dx[32] ? 33'(-dx) : 33'(dx);
   assign ay = dy[32] ? 33'(-dy) : 33'(dy);

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      mul_signed = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            mul_a = 33'(req_data.quat_w); mul_b = 33'(req_data.quat_z);
         end
         S_M0: begin
            mul_a = 33'(item_ff.quat_x); mul_b = 33'(item_ff.quat_y);
         end
         S_M1: begin
            mul_a = 33'(item_ff.quat_y); mul_b = 33'(item_ff.quat_y);
         end
         S_M2: begin
            mul_a = 33'(item_ff.quat_z); mul_b = 33'(item_ff.quat_z);
         end
         S_M3: begin
            mul_a = {9'd0, leg_len_ff}; mul_b = {9'd0, leg_len_ff};
            mul_signed = 1'b0;
         end
         S_ATAN, S_WAIT: begin
            mul_a = ax; mul_b = ax; mul_signed = 1'b0;
         end
         S_D0: begin
            mul_a = ay; mul_b = ay; mul_signed = 1'b0;
         end
         default: ;
      endcase
      if (mul_signed) prod_s = $signed(mul_a) * $signed(mul_b);
      else            prod_s = $signed({1'b0, 65'(mul_a * mul_b)});
   end

   // heading change, wrapped into [-pi, pi], magnitude
   logic signed [17:0] dh, dh_w, dh_abs;
   always_comb begin
      dh = 18'(heading_ff) - 18'(start_h_ff);
      if (dh > 18'(Q13Pi))       dh_w = dh - Q13TwoPi;
      else if (dh < -18'(Q13Pi)) dh_w = dh + Q13TwoPi;
      else                        dh_w = dh;
      dh_abs = dh_w[17] ? -dh_w : dh_w;
   end

   logic [63:0] d2_sat;
   assign d2_sat = d2_ff[64] ? {64{1'b1}} : d2_ff[63:0];

   // cos is complete only after the S_M3 edge
   assign cordic_start = (state_ff == S_ATAN);

   spls_cordic #(.AngleIterations(ANGLE_ITERATIONS)) u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cordic_start),
      .y_in  (sin_ff),
      .x_in  (cos_ff),
      .done  (cordic_done),
      .angle (cordic_angle)
   );

   logic req_acc, rsp_acc, rsp_load;
   assign req_acc = req_valid && !req_stall;
   assign rsp_acc = rsp_valid_ff && !rsp_stall;
   assign rsp_load = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_acc);
   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   // decide step, combinational from registered values
   logic fwd_n, done_n;
   logic [1:0] side_n;
   logic [7:0] lap_n;
   logic leg_end;
   always_comb begin
      fwd_n = fwd_ff; side_n = side_ff; lap_n = lap_ff; done_n = done_flag_ff;
      leg_end = 1'b0;
      if (!done_flag_ff) begin
         if (fwd_ff) begin
            if (d2_sat >= side2_ff) begin
               fwd_n = 1'b0; leg_end = 1'b1;
            end
         end else if (dh_abs >= 18'(Q13HalfPi)) begin
            fwd_n = 1'b1; leg_end = 1'b1;
            if (side_ff == SidesLast) begin
               side_n = '0;
               if (lap_ff != 8'd255) lap_n = lap_ff + 1'b1;
            end else begin
               side_n = side_ff + 1'b1;
            end
         end
         if (lap_n >= lap_target_ff) done_n = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_s;
      if (req_acc) item_ff <= req_data;
      unique case (state_ff)
         S_M0: sin_ff <= 34'(prod_ff);
         S_M1: sin_ff <= (sin_ff + 34'(prod_ff)) <<< 1;
         S_M2: cos_ff <= 34'sd268435456 - (34'(prod_ff) <<< 1);
         S_M3: cos_ff <= cos_ff - (34'(prod_ff) <<< 1);
         S_ATAN: side2_ff <= prod_ff[63:0];
         S_D0: d2_ff <= {1'b0, prod_ff[63:0]};
         S_D1: d2_ff <= d2_ff + {1'b0, prod_ff[63:0]};
         default: ;
      endcase
      if (cordic_done) heading_ff <= cordic_angle;
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         leg_len_ff <= 24'd65536;
         lap_target_ff <= 8'd1;
         turn_cw_ff <= 1'b0;
         fwd_ff <= 1'b1; side_ff <= '0; lap_ff <= '0;
         start_x_ff <= '0; start_y_ff <= '0; start_h_ff <= '0;
         done_flag_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CsrSideLength:    leg_len_ff <= csr_wdata;
               CsrLapTarget:     lap_target_ff <= csr_wdata[7:0];
               CsrTurnClockwise: turn_cw_ff <= csr_wdata[0];
               default: ;
            endcase
         end
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_acc) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: if (req_acc) state_ff <= S_M0;
            S_M0: state_ff <= S_M1;
            S_M1: state_ff <= S_M2;
            S_M2: state_ff <= S_M3;
            S_M3: state_ff <= S_ATAN;
            S_ATAN: state_ff <= S_WAIT;
            S_WAIT: if (cordic_done) state_ff <= S_D0;
            S_D0: state_ff <= S_D1;
            S_D1: state_ff <= S_DECIDE;
            S_DECIDE: begin
               fwd_ff <= fwd_n; side_ff <= side_n; lap_ff <= lap_n;
               done_flag_ff <= done_n;
               if (leg_end) begin
                  start_x_ff <= item_ff.pos_x;
                  start_y_ff <= item_ff.pos_y;
                  start_h_ff <= heading_ff;
               end
               state_ff <= S_OUT;
            end
            S_OUT: begin
               // hold here while the previous result is still stalled
               if (rsp_load) begin
                  rsp_ff.heading <= heading_ff;
                  rsp_ff.side_index <= side_ff;
                  rsp_ff.laps_done <= lap_ff;
                  rsp_ff.finished <= done_flag_ff;
                  rsp_ff.linear_speed <= (!done_flag_ff && fwd_ff) ? FwdSpeed : 8'd0;
                  rsp_ff.turning <= !done_flag_ff && !fwd_ff;
                  rsp_ff.angular_speed <= (!done_flag_ff && !fwd_ff) ?
                     (turn_cw_ff ? TurnRight : TurnLeft) : 10'sd0;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff && $stable(rsp_ff))
      else $error("stalled result changed");
   assert property (@(posedge clock) disable iff (reset)
      done_flag_ff && state_ff == S_DECIDE |=> $stable(lap_ff) && $stable(side_ff))
      else $error("counts moved after finish");
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_OUT |=> rsp_valid_ff)
      else $error("result not presented");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.finished |-> rsp_ff.linear_speed == 8'd0 && !rsp_ff.turning)
      else $error("speed after finish");

endmodule

@@ rtl/spls_cordic.sv @@
// Iterative CORDIC arctangent (vectoring mode), one rotation per cycle.
module spls_cordic import spls_pkg::*; #(
   parameter int AngleIterations = AngleIterationsDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [33:0] y_in,
   input  logic signed [33:0] x_in,
   output logic               done,
   output logic signed [15:0] angle
);

   localparam int CntW = $clog2(AngleIterations + 1);
   // x grows by at most ~1.65 over the iterations
   localparam int VecW = 36;

   logic signed [VecW-1:0] x_ff, x_in_next, y_ff, y_in_next;
   logic signed [17:0] z_ff, z_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic signed [VecW-1:0] xs, ys;
   logic signed [17:0] step;

   always_comb begin
      xs = x_ff >>> cnt_ff;
      ys = y_ff >>> cnt_ff;
      step = 18'(atan_entry(5'(cnt_ff)));
      x_in_next = x_ff;
      y_in_next = y_ff;
      z_in = z_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         cnt_in = '0;
         z_in = '0;
         x_in_next = VecW'(x_in);
         y_in_next = VecW'(y_in);
         if (x_in == 34'sd0 && y_in == 34'sd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            busy_in = 1'b1;
            if (x_in < 0) begin
               z_in = (y_in >= 0) ? 18'(Q13Pi) : -18'(Q13Pi);
               x_in_next = -VecW'(x_in);
               y_in_next = -VecW'(y_in);
            end
         end
      end else if (busy_ff) begin
         if (cnt_ff == CntW'(AngleIterations)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            if (y_ff >= 0) begin
               x_in_next = x_ff + ys; y_in_next = y_ff - xs; z_in = z_ff + step;
            end else begin
               x_in_next = x_ff - ys; y_in_next = y_ff + xs; z_in = z_ff - step;
            end
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in_next;
      y_ff <= y_in_next;
      z_ff <= z_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   always_comb begin
      if (z_ff > 18'(Q13Pi))       angle = Q13Pi;
      else if (z_ff < -18'(Q13Pi)) angle = -Q13Pi;
      else                          angle = 16'(z_ff);
   end

   assert property (@(posedge clock) disable iff (reset) done_ff |-> !busy_ff)
      else $error("cordic done while busy");
   assert property (@(posedge clock) disable iff (reset) busy_ff |-> !done_ff)
      else $error("cordic busy and done");
   assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff <= CntW'(AngleIterations))
      else $error("cordic count overrun");

endmodule

@@ verif/square_path_leg_sequencer_tb.sv @@
// Testbench for the square path leg sequencer: directed and random odometry, result checking.
`timescale 1ns / 100ps

module square_path_leg_sequencer_tb;
   import spls_pkg::*;

   localparam int HeadingSteps = 14;
   localparam int WatchdogLimit = 20000;
   localparam logic [1:0] CsrUnused = 2'd3;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [23:0] csr_wdata;

   square_path_leg_sequencer u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // navigation state mirror
   logic [23:0]        nav_side_len;
   logic [7:0]         nav_lap_target;
   logic               nav_clockwise;
   logic               nav_forward;
   logic [1:0]         nav_side;
   logic [7:0]         nav_laps;
   logic signed [31:0] nav_start_x;
   logic signed [31:0] nav_start_y;
   logic signed [31:0] nav_start_hdg;
   logic               nav_done;

   rsp_type expected_cmds[$];
   int send_idle_pct;
   int recv_stall_pct;
   int mismatches;
   int items_sent;
   int results_seen;
   int idle_cycles;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic signed [31:0] yaw_of(req_type r);
      longint sn, cs, xs, ys, z, x, y;
      int i;
      int tbl[14] = '{6434, 3798, 2007, 1019, 511, 256, 128, 64, 32, 16, 8, 4, 2, 1};
      sn = 2 * (longint'(r.quat_w) * r.quat_z + longint'(r.quat_x) * r.quat_y);
      cs = (64'sd1 <<< 28) - 2 * (longint'(r.quat_y) * r.quat_y
                                  + longint'(r.quat_z) * r.quat_z);
      x = cs;
      y = sn;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         z = (y >= 0) ? 25736 : -25736;
         x = -x;
         y = -y;
      end
      for (i = 0; i < HeadingSteps; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x += ys; y -= xs; z += tbl[i];
         end else begin
            x -= ys; y += xs; z -= tbl[i];
         end
      end
      if (z > 25736) z = 25736;
      if (z < -25736) z = -25736;
      return 32'(z);
   endfunction

   function automatic rsp_type predict_command(req_type r);
      rsp_type o;
      logic signed [31:0] hdg, dh;
      longint ax, ay;
      logic [63:0] d2, e2, sum, side2;
      hdg = yaw_of(r);
      if (!nav_done) begin
         ax = longint'(r.pos_x) - longint'(nav_start_x);
         ay = longint'(r.pos_y) - longint'(nav_start_y);
         if (ax < 0) ax = -ax;
         if (ay < 0) ay = -ay;
         d2 = 64'(ax) * 64'(ax);
         e2 = 64'(ay) * 64'(ay);
         sum = d2 + e2;
         if (sum < d2) sum = '1;
         side2 = 64'(nav_side_len) * 64'(nav_side_len);
         dh = hdg - nav_start_hdg;
         if (dh > 25736) dh -= 51472;
         else if (dh < -25736) dh += 51472;
         if (dh < 0) dh = -dh;
         if (nav_forward) begin
            if (sum >= side2) begin
               nav_forward = 1'b0;
               nav_start_x = r.pos_x; nav_start_y = r.pos_y; nav_start_hdg = hdg;
            end
         end else if (dh >= 12868) begin
            nav_forward = 1'b1;
            nav_start_x = r.pos_x; nav_start_y = r.pos_y; nav_start_hdg = hdg;
            if (nav_side == SidesLast) begin
               nav_side = 2'd0;
               if (nav_laps != 8'd255) nav_laps++;
            end else begin
               nav_side++;
            end
         end
         if (nav_laps >= nav_lap_target) nav_done = 1'b1;
      end
      o = '0;
      if (!nav_done) begin
         if (nav_forward) o.linear_speed = FwdSpeed;
         else begin
            o.angular_speed = nav_clockwise ? TurnRight : TurnLeft;
            o.turning = 1'b1;
         end
      end
      o.heading = hdg[15:0];
      o.side_index = nav_side;
      o.laps_done = nav_laps;
      o.finished = nav_done;
      return o;
   endfunction

   task automatic nav_reset_model();
      nav_side_len = 24'd65536; nav_lap_target = 8'd1; nav_clockwise = 1'b0;
      nav_forward = 1'b1; nav_side = '0; nav_laps = '0;
      nav_start_x = '0; nav_start_y = '0; nav_start_hdg = '0; nav_done = 1'b0;
   endtask

   // receiver stall and result checking
   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b1;
      else rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (expected_cmds.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", rsp_data);
         end else begin
            rsp_type e;
            e = expected_cmds.pop_front();
            if (e !== rsp_data) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %p actual %p", e, rsp_data);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
         $display("watchdog: no progress");
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // valid stays up after an accept until the next item or an idle cycle
   task automatic send_odometry(req_type r);
      rsp_type pred;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pred = predict_command(r);
      expected_cmds = {expected_cmds, pred};
      items_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_cmds.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [23:0] val);
      drain();
      csr_valid <= 1'b1; csr_index <= idx; csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CsrSideLength) nav_side_len = val;
      else if (idx == CsrLapTarget) nav_lap_target = val[7:0];
      else if (idx == CsrTurnClockwise) nav_clockwise = val[0];
   endtask

   function automatic req_type make_pose(int x, int y, int yaw_q14_w, int yaw_q14_z);
      req_type r;
      r = '0;
      r.pos_x = x; r.pos_y = y;
      r.quat_w = 16'(yaw_q14_w); r.quat_z = 16'(yaw_q14_z);
      return r;
   endfunction

   function automatic req_type random_pose();
      req_type r;
      r.pos_x = $urandom; r.pos_y = $urandom;
      r.quat_w = 16'($urandom_range(32768) - 16384);
      r.quat_x = 16'($urandom_range(32768) - 16384);
      r.quat_y = 16'($urandom_range(32768) - 16384);
      r.quat_z = 16'($urandom_range(32768) - 16384);
      return r;
   endfunction

   task automatic test_field_extremes();
      req_type r;
      send_odometry(make_pose(0, 0, 0, 0));            // degenerate quaternion
      send_odometry(make_pose(32'h7fffffff, 32'h80000000, 16384, 0));
      r = '{32'h80000000, 32'h7fffffff, -16'sd16384, 16'sd16384, -16'sd16384, 16'sd16384};
      send_odometry(r);
      r = '{32'h7fffffff, 32'h7fffffff, 16'sd0, 16'sd0, 16'sd0, 16'sd16384}; // yaw = pi
      send_odometry(r);
      r = '{-32'sd1, 32'sd0, 16'sd0, -16'sd16384, 16'sd16384, -16'sd16384};
      send_odometry(r);
      send_odometry(make_pose(0, 0, 0, -16384));
   endtask

   // drive a square path: straight legs, each followed by three 45-degree heading steps, with an occasional random pose
   task automatic test_square_laps(int legs, int step_div);
      int x, y, ang, k, s;
      int dirx[4] = '{1, 0, -1, 0};
      int diry[4] = '{0, 1, 0, -1};
      int cs[8] = '{16384, 15137, 11585, 6270, 0, -6270, -11585, -15137};
      int sn[8] = '{0, 6270, 11585, 15137, 16384, 15137, 11585, 6270};
      x = $urandom_range(1000); y = $urandom_range(1000); ang = 0;
      for (k = 0; k < legs; k++) begin
         for (s = 0; s <= step_div; s++) begin
            x += dirx[k % 4] * int'(nav_side_len) / step_div;
            y += diry[k % 4] * int'(nav_side_len) / step_div;
            send_odometry(make_pose(x, y, cs[ang % 8], sn[ang % 8] *
                          (ang % 8 == 0 ? 1 : 1)));
         end
         for (s = 0; s < 3; s++) begin
            ang = (ang + (nav_clockwise ? 7 : 1)) % 8;
            send_odometry(make_pose(x, y, cs[ang], sn[ang]));
         end
         if ($urandom_range(9) == 0) send_odometry(random_pose());
      end
   endtask

   task automatic test_random_noise(int n);
      repeat (n) send_odometry(random_pose());
   endtask

   initial begin
      reset = 1'b1; req_valid = 1'b0; req_data = '0;
      csr_valid = 1'b0; csr_index = '0; csr_wdata = '0;
      send_idle_pct = 30; recv_stall_pct = 85;
      mismatches = 0; items_sent = 0; results_seen = 0;
      nav_reset_model();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_field_extremes();
      write_csr(CsrLapTarget, 24'd0);      // immediate finish
      send_odometry(make_pose(5, 5, 16384, 0));
      drain();                             // sender holds until all results are in
      write_csr(CsrUnused, 24'hffffff);
      test_random_noise(3);

      send_idle_pct = 85; recv_stall_pct = 30;
      test_random_noise(4);
      write_csr(CsrSideLength, 24'd0);
      write_csr(CsrLapTarget, 24'd255);
      test_square_laps(8, 1);
      write_csr(CsrSideLength, 24'hffffff);
      write_csr(CsrTurnClockwise, 24'd1);
      test_random_noise(20);

      send_idle_pct = 0; recv_stall_pct = 0;
      write_csr(CsrSideLength, 24'd4096);
      write_csr(CsrLapTarget, 24'd2);
      test_square_laps(16, 3);
      test_square_laps(10, 2);
      write_csr(CsrTurnClockwise, 24'd0);
      write_csr(CsrLapTarget, 24'd200);
      write_csr(CsrSideLength, 24'd65536);
      test_square_laps(20, 2);
      test_random_noise(60);
      drain();

      $display("covered %0d odometry items, %0d results, square laps both directions",
               items_sent, results_seen);
      $display("side length, lap target and turn direction swept incl. extremes");
      if (mismatches == 0 && expected_cmds.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("mismatches: %0d", mismatches);
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
